// ===== rtl/core/stt_pkg.sv =====
// Shared widths, command and result codes, and the slot entry layout of the timer table.
package stt_pkg;

  localparam int NUM_TIMERS_DEFAULT = 32;

  localparam int CMD_W  = 2;
  localparam int DUR_W  = 31;
  localparam int EVT_W  = 16;
  localparam int TASK_W = 16;
  localparam int PAY_W  = 32;
  localparam int TICK_W = 32;
  localparam int KIND_W = 2;

  localparam logic [CMD_W-1:0] CMD_TICK         = 2'd0;
  localparam logic [CMD_W-1:0] CMD_SET_ONCE     = 2'd1;
  localparam logic [CMD_W-1:0] CMD_SET_PERIODIC = 2'd2;
  localparam logic [CMD_W-1:0] CMD_KILL         = 2'd3;

  localparam logic [KIND_W-1:0] KIND_ACCEPT = 2'd0;
  localparam logic [KIND_W-1:0] KIND_REJECT = 2'd1;
  localparam logic [KIND_W-1:0] KIND_EXPIRE = 2'd2;

  typedef struct packed {
    logic              used;
    logic              periodic;
    logic [TICK_W-1:0] start;
    logic [DUR_W-1:0]  length;
    logic [EVT_W-1:0]  event_code;
    logic [TASK_W-1:0] owner_task;
    logic [PAY_W-1:0]  payload;
  } slot_entry_t;

  localparam int ENTRY_W = $bits(slot_entry_t);

endpackage

// ===== rtl/core/stt_if.sv =====
// Valid/ready channel interfaces for timer commands and timer results.
interface stt_req_if
  import stt_pkg::*;
#(
  parameter int NUM_TIMERS = NUM_TIMERS_DEFAULT
) ();
  localparam int SLOT_W = $clog2(NUM_TIMERS);

  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  command;
  logic [DUR_W-1:0]  duration;
  logic [EVT_W-1:0]  event_code;
  logic [TASK_W-1:0] owner_task;
  logic [PAY_W-1:0]  payload_word;
  logic [SLOT_W-1:0] slot_index;

  modport source (
    output valid, command, duration, event_code, owner_task, payload_word, slot_index,
    input  ready
  );
  modport sink (
    input  valid, command, duration, event_code, owner_task, payload_word, slot_index,
    output ready
  );
endinterface

interface stt_rsp_if
  import stt_pkg::*;
#(
  parameter int NUM_TIMERS = NUM_TIMERS_DEFAULT
) ();
  localparam int SLOT_W = $clog2(NUM_TIMERS);

  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] kind;
  logic [SLOT_W-1:0] slot;
  logic [EVT_W-1:0]  fired_event;
  logic [TASK_W-1:0] fired_task;
  logic [PAY_W-1:0]  fired_payload;
  logic              last;

  modport source (
    output valid, kind, slot, fired_event, fired_task, fired_payload, last,
    input  ready
  );
  modport sink (
    input  valid, kind, slot, fired_event, fired_task, fired_payload, last,
    output ready
  );
endinterface

// ===== rtl/core/stt_ram.sv =====
// Simple dual-port slot memory: one write port, one read port with registered data.
module stt_ram #(
  parameter int DEPTH = 32,
  parameter int WIDTH = 8,
  localparam int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== rtl/core/software_timer_table.sv =====
// Top level of the software timer table: command sequencer around the slot memory.
//
//   channel  dir  payload                                                     transaction
//   req      in   command, duration, event_code, owner_task, payload_word,    valid & ready
//                 slot_index
//   rsp      out  kind, slot, fired_event, fired_task, fired_payload, last    valid & ready
//
// A kill clears its slot directly from the idle state, without a scan. A tick reads the slot
// memory one entry per cycle through its single read port, unless the scan is stalled, and each
// entry is written back as it is judged. A set scans the same way until the first free slot.
// After reset a clearing pass marks every slot free, with req.ready low.
// A result waiting in the output register holds the scan only when a second expiry needs room.
module software_timer_table
  import stt_pkg::*;
#(
  parameter int NUM_TIMERS = NUM_TIMERS_DEFAULT
) (
  input  logic      clk,
  input  logic      rst,
  stt_req_if.sink   req,
  stt_rsp_if.source rsp
);

  localparam int SLOT_W = $clog2(NUM_TIMERS);
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(NUM_TIMERS - 1);
  localparam logic [SLOT_W:0]   NUM_SLOTS = (SLOT_W + 1)'(NUM_TIMERS);

  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_SCAN  = 2'd2;
  localparam logic [1:0] ST_FLUSH = 2'd3;

  logic [1:0]        state;
  logic [SLOT_W-1:0] clr_idx;
  logic [TICK_W-1:0] now_tick;

  // Latched set command.
  logic              op_set;
  logic              op_periodic;
  logic [DUR_W-1:0]  op_duration;
  logic [EVT_W-1:0]  op_event;
  logic [TASK_W-1:0] op_task;
  logic [PAY_W-1:0]  op_payload;

  // Scan pipeline: read issue, then evaluation of the returned entry.
  logic              iss_active;
  logic [SLOT_W-1:0] iss_idx;
  logic              q_valid;
  logic [SLOT_W-1:0] q_idx;

  // Result held back until it is known whether it is the last one.
  logic              pend_valid;
  logic [KIND_W-1:0] pend_kind;
  logic [SLOT_W-1:0] pend_slot;
  logic [EVT_W-1:0]  pend_event;
  logic [TASK_W-1:0] pend_task;
  logic [PAY_W-1:0]  pend_payload;

  logic              out_valid;
  logic [KIND_W-1:0] out_kind;
  logic [SLOT_W-1:0] out_slot;
  logic [EVT_W-1:0]  out_event;
  logic [TASK_W-1:0] out_task;
  logic [PAY_W-1:0]  out_payload;
  logic              out_last;

  logic               wr_en;
  logic [SLOT_W-1:0]  wr_addr;
  slot_entry_t        wr_entry;
  logic               rd_en;
  logic [ENTRY_W-1:0] rd_data;
  slot_entry_t        entry;

  logic [TICK_W-1:0] elapsed;
  logic              expired;
  logic              out_free;
  logic              stall;
  logic              advance;
  logic              out_load;
  logic              last_q;
  logic              req_acc;
  logic              kill_ok;

  stt_ram #(
    .DEPTH (NUM_TIMERS),
    .WIDTH (ENTRY_W)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_entry),
    .rd_en   (rd_en),
    .rd_addr (iss_idx),
    .rd_data (rd_data)
  );

  assign req.ready = (state == ST_IDLE);
  assign req_acc   = req.valid && req.ready;
  assign kill_ok   = ({1'b0, req.slot_index} < NUM_SLOTS);

  assign entry    = slot_entry_t'(rd_data);
  assign elapsed  = now_tick - entry.start;
  assign expired  = entry.used && (elapsed >= {1'b0, entry.length});
  assign out_free = !out_valid || rsp.ready;
  assign last_q   = (q_idx == LAST_SLOT);

  // Only a second expiry in one tick needs the output register; everything else proceeds.
  assign stall   = (state == ST_SCAN) && q_valid && !op_set && expired && pend_valid
                   && !out_free;
  assign advance = !stall;
  assign rd_en   = (state == ST_SCAN) && iss_active && advance;

  // The output register takes a new result in this cycle.
  assign out_load = ((state == ST_SCAN) && q_valid && advance && !op_set && expired
                     && pend_valid)
                    || ((state == ST_FLUSH) && pend_valid && out_free);

  always_comb begin
    wr_en    = 1'b0;
    wr_addr  = q_idx;
    wr_entry = entry;
    unique case (state)
      ST_CLEAR: begin
        wr_en    = 1'b1;
        wr_addr  = clr_idx;
        wr_entry = '0;
      end
      ST_IDLE: begin
        wr_en    = req_acc && (req.command == CMD_KILL) && kill_ok;
        wr_addr  = req.slot_index;
        wr_entry = '0;
      end
      ST_SCAN: begin
        if (q_valid && advance) begin
          if (op_set) begin
            wr_en               = !entry.used;
            wr_entry.used       = 1'b1;
            wr_entry.periodic   = op_periodic;
            wr_entry.start      = now_tick;
            wr_entry.length     = op_duration;
            wr_entry.event_code = op_event;
            wr_entry.owner_task = op_task;
            wr_entry.payload    = op_payload;
          end else begin
            wr_en = expired;
            if (entry.periodic) begin
              wr_entry.start = now_tick;
            end else begin
              wr_entry.used = 1'b0;
            end
          end
        end
      end
      ST_FLUSH: begin
        wr_en = 1'b0;
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_CLEAR;
      clr_idx    <= '0;
      now_tick   <= '0;
      iss_active <= 1'b0;
      iss_idx    <= '0;
      q_valid    <= 1'b0;
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
      op_set     <= 1'b0;
    end else begin
      if (out_valid && rsp.ready && !out_load) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        ST_CLEAR: begin
          clr_idx <= clr_idx + 1'b1;
          if (clr_idx == LAST_SLOT) begin
            state <= ST_IDLE;
          end
        end

        ST_IDLE: begin
          if (req_acc) begin
            iss_idx    <= '0;
            iss_active <= 1'b1;
            q_valid    <= 1'b0;
            unique case (req.command)
              CMD_TICK: begin
                now_tick <= now_tick + 1'b1;
                op_set   <= 1'b0;
                state    <= ST_SCAN;
              end
              CMD_SET_ONCE, CMD_SET_PERIODIC: begin
                op_set      <= 1'b1;
                op_periodic <= (req.command == CMD_SET_PERIODIC);
                op_duration <= req.duration;
                op_event    <= req.event_code;
                op_task     <= req.owner_task;
                op_payload  <= req.payload_word;
                if (req.duration == '0) begin
                  pend_valid   <= 1'b1;
                  pend_kind    <= KIND_REJECT;
                  pend_slot    <= '0;
                  pend_event   <= '0;
                  pend_task    <= '0;
                  pend_payload <= '0;
                  state        <= ST_FLUSH;
                end else begin
                  state <= ST_SCAN;
                end
              end
              CMD_KILL: begin
                state <= ST_IDLE;
              end
              default: begin
                state <= ST_IDLE;
              end
            endcase
          end
        end

        ST_SCAN: begin
          if (advance) begin
            q_valid <= rd_en;
            q_idx   <= iss_idx;
            if (rd_en) begin
              if (iss_idx == LAST_SLOT) begin
                iss_active <= 1'b0;
              end else begin
                iss_idx <= iss_idx + 1'b1;
              end
            end
            if (q_valid) begin
              if (op_set) begin
                if (!entry.used) begin
                  pend_valid   <= 1'b1;
                  pend_kind    <= KIND_ACCEPT;
                  pend_slot    <= q_idx;
                  pend_event   <= '0;
                  pend_task    <= '0;
                  pend_payload <= '0;
                  state        <= ST_FLUSH;
                end else if (last_q) begin
                  pend_valid   <= 1'b1;
                  pend_kind    <= KIND_REJECT;
                  pend_slot    <= '0;
                  pend_event   <= '0;
                  pend_task    <= '0;
                  pend_payload <= '0;
                  state        <= ST_FLUSH;
                end
              end else begin
                if (expired) begin
                  // The held expiry is not the last one, so it leaves now.
                  if (pend_valid) begin
                    out_valid   <= 1'b1;
                    out_kind    <= pend_kind;
                    out_slot    <= pend_slot;
                    out_event   <= pend_event;
                    out_task    <= pend_task;
                    out_payload <= pend_payload;
                    out_last    <= 1'b0;
                  end
                  pend_valid   <= 1'b1;
                  pend_kind    <= KIND_EXPIRE;
                  pend_slot    <= q_idx;
                  pend_event   <= entry.event_code;
                  pend_task    <= entry.owner_task;
                  pend_payload <= entry.payload;
                end
                if (last_q) begin
                  state <= ST_FLUSH;
                end
              end
            end
          end
        end

        ST_FLUSH: begin
          q_valid    <= 1'b0;
          iss_active <= 1'b0;
          if (!pend_valid) begin
            state <= ST_IDLE;
          end else if (out_free) begin
            out_valid   <= 1'b1;
            out_kind    <= pend_kind;
            out_slot    <= pend_slot;
            out_event   <= pend_event;
            out_task    <= pend_task;
            out_payload <= pend_payload;
            out_last    <= 1'b1;
            pend_valid  <= 1'b0;
            state       <= ST_IDLE;
          end
        end

        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  assign rsp.valid         = out_valid;
  assign rsp.kind          = out_kind;
  assign rsp.slot          = out_slot;
  assign rsp.fired_event   = out_event;
  assign rsp.fired_task    = out_task;
  assign rsp.fired_payload = out_payload;
  assign rsp.last          = out_last;

`ifndef SYNTH
  // The scan writes back the entry it judged while reading the next one.
  a_no_rw_collision: assert property (@(posedge clk) disable iff (rst)
    (wr_en && rd_en) |-> (wr_addr != iss_idx))
    else $error("slot memory read and write hit the same entry");

  a_set_result_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (out_kind != KIND_EXPIRE)) |-> out_last)
    else $error("set answer without last flag");

  a_kill_silent: assert property (@(posedge clk) disable iff (rst)
    (req_acc && (req.command == CMD_KILL) && !out_valid) |=> !out_valid)
    else $error("kill produced a result");

  a_tick_only_advances: assert property (@(posedge clk) disable iff (rst)
    !(req_acc && (req.command == CMD_TICK)) |=> $stable(now_tick))
    else $error("time count moved without a tick");

  a_pend_empty_when_idle: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> !pend_valid)
    else $error("held result left behind after a command");
`endif

endmodule

// ===== bench/timer_table_checker.sv =====
// Result checker for the timer table: mirrors the slot table and compares every result.
`timescale 1ns / 100ps

module timer_table_checker
  import stt_pkg::*;
#(
  parameter int NUM_TIMERS = NUM_TIMERS_DEFAULT
) (
  input  logic clk,
  input  logic rst,
  stt_req_if   req,
  stt_rsp_if   rsp,
  output int   mismatches,
  output int   pending
);
  localparam int SLOT_W = $clog2(NUM_TIMERS);

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [SLOT_W-1:0] slot;
    logic [EVT_W-1:0]  fired_event;
    logic [TASK_W-1:0] fired_task;
    logic [PAY_W-1:0]  fired_payload;
    logic              last;
  } timer_result_t;

  timer_result_t     awaited[$];
  int                bad_count;

  logic [TICK_W-1:0] now_tick;
  logic              slot_used     [NUM_TIMERS];
  logic              slot_periodic [NUM_TIMERS];
  logic [TICK_W-1:0] slot_start    [NUM_TIMERS];
  logic [DUR_W-1:0]  slot_length   [NUM_TIMERS];
  logic [EVT_W-1:0]  slot_event    [NUM_TIMERS];
  logic [TASK_W-1:0] slot_owner    [NUM_TIMERS];
  logic [PAY_W-1:0]  slot_payload  [NUM_TIMERS];

  initial begin
    bad_count = 0;
    mismatches <= 0;
    pending <= 0;
  end

  task automatic clear_table();
    awaited.delete();
    now_tick = '0;
    for (int i = 0; i < NUM_TIMERS; i++) begin
      slot_used[i] = 1'b0;
      slot_periodic[i] = 1'b0;
    end
  endtask

  // Works out the results one command causes and updates the mirrored table.
  task automatic apply_command(input logic [CMD_W-1:0] cmd, input logic [DUR_W-1:0] dur,
                               input logic [EVT_W-1:0] ev, input logic [TASK_W-1:0] owner,
                               input logic [PAY_W-1:0] pay, input logic [SLOT_W-1:0] idx);
    timer_result_t     r;
    logic [TICK_W-1:0] age;
    int                fired;
    int                found;
    fired = 0;
    found = -1;
    r = '0;
    case (cmd)
      CMD_TICK: begin
        now_tick = now_tick + 1;
        for (int i = 0; i < NUM_TIMERS; i++) begin
          if (slot_used[i]) begin
            age = now_tick - slot_start[i];
            if (age >= {1'b0, slot_length[i]}) begin
              r.kind = KIND_EXPIRE;
              r.slot = SLOT_W'(i);
              r.fired_event = slot_event[i];
              r.fired_task = slot_owner[i];
              r.fired_payload = slot_payload[i];
              r.last = 1'b0;
              awaited.push_back(r);
              fired++;
              if (slot_periodic[i]) slot_start[i] = now_tick;
              else slot_used[i] = 1'b0;
            end
          end
        end
        if (fired > 0) begin
          r = awaited[awaited.size() - 1];
          r.last = 1'b1;
          awaited[awaited.size() - 1] = r;
        end
      end
      CMD_SET_ONCE, CMD_SET_PERIODIC: begin
        if (dur != '0) begin
          for (int i = 0; i < NUM_TIMERS; i++) begin
            if (found < 0 && !slot_used[i]) found = i;
          end
        end
        r.last = 1'b1;
        if (found < 0) begin
          r.kind = KIND_REJECT;
        end else begin
          slot_used[found] = 1'b1;
          slot_periodic[found] = (cmd == CMD_SET_PERIODIC);
          slot_start[found] = now_tick;
          slot_length[found] = dur;
          slot_event[found] = ev;
          slot_owner[found] = owner;
          slot_payload[found] = pay;
          r.kind = KIND_ACCEPT;
          r.slot = SLOT_W'(found);
        end
        awaited.push_back(r);
      end
      CMD_KILL: begin
        if (int'(idx) < NUM_TIMERS && slot_used[idx]) begin
          slot_used[idx] = 1'b0;
          slot_periodic[idx] = 1'b0;
        end
      end
      default: ;
    endcase
  endtask

  task automatic check_result();
    timer_result_t want;
    if (awaited.size() == 0) begin
      bad_count++;
      if (bad_count <= 10)
        $display("%0t: unexpected result kind=%0d slot=%0d event=%h task=%h payload=%h last=%b",
                 $realtime, rsp.kind, rsp.slot, rsp.fired_event, rsp.fired_task,
                 rsp.fired_payload, rsp.last);
    end else begin
      want = awaited.pop_front();
      if (rsp.kind !== want.kind || rsp.slot !== want.slot ||
          rsp.fired_event !== want.fired_event || rsp.fired_task !== want.fired_task ||
          rsp.fired_payload !== want.fired_payload || rsp.last !== want.last) begin
        bad_count++;
        if (bad_count <= 10) begin
          $display("%0t: result mismatch", $realtime);
          $display("  expected kind=%0d slot=%0d event=%h task=%h payload=%h last=%b",
                   want.kind, want.slot, want.fired_event, want.fired_task,
                   want.fired_payload, want.last);
          $display("  actual   kind=%0d slot=%0d event=%h task=%h payload=%h last=%b",
                   rsp.kind, rsp.slot, rsp.fired_event, rsp.fired_task,
                   rsp.fired_payload, rsp.last);
        end
      end
    end
  endtask

  // A result accepted at this edge always belongs to an earlier command, so it is
  // checked before the command accepted at the same edge is predicted.
  always @(posedge clk) begin
    if (rst) begin
      clear_table();
    end else begin
      if (rsp.valid === 1'b1 && rsp.ready === 1'b1) check_result();
      if (req.valid === 1'b1 && req.ready === 1'b1)
        apply_command(req.command, req.duration, req.event_code, req.owner_task,
                      req.payload_word, req.slot_index);
    end
    pending <= awaited.size();
    mismatches <= bad_count;
  end

endmodule

// ===== bench/tb_software_timer_table.sv =====
// Testbench top for the timer table: clock, reset, command stimulus and result flow control.
`timescale 1ns / 100ps

module tb_software_timer_table;
  import stt_pkg::*;

  localparam int NUM_TIMERS = NUM_TIMERS_DEFAULT;
  localparam int SLOT_W = $clog2(NUM_TIMERS);

  logic clk;
  logic rst;
  logic hold_req;
  int   mismatches;
  int   pending;
  int   burst_left;

  stt_req_if #(.NUM_TIMERS(NUM_TIMERS)) req_if ();
  stt_rsp_if #(.NUM_TIMERS(NUM_TIMERS)) rsp_if ();

  software_timer_table #(.NUM_TIMERS(NUM_TIMERS)) DUT (
    .clk (clk),
    .rst (rst),
    .req (req_if),
    .rsp (rsp_if)
  );

  timer_table_checker #(.NUM_TIMERS(NUM_TIMERS)) results_check (
    .clk        (clk),
    .rst        (rst),
    .req        (req_if),
    .rsp        (rsp_if),
    .mismatches (mismatches),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("TB_ERROR");
    $finish;
  end

  // Offers one command, waits for its transaction, then keeps the burst going or
  // drops valid for a random gap.
  task automatic issue(input logic [CMD_W-1:0] cmd, input logic [DUR_W-1:0] dur,
                       input logic [EVT_W-1:0] ev, input logic [TASK_W-1:0] owner,
                       input logic [PAY_W-1:0] pay, input logic [SLOT_W-1:0] idx);
    req_if.valid <= 1'b1;
    req_if.command <= cmd;
    req_if.duration <= dur;
    req_if.event_code <= ev;
    req_if.owner_task <= owner;
    req_if.payload_word <= pay;
    req_if.slot_index <= idx;
    @(posedge clk);
    while (req_if.ready !== 1'b1) @(posedge clk);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      req_if.valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = ($urandom_range(0, 5) == 0) ? 40 : $urandom_range(0, 10);
    end
  endtask

  task automatic random_command(input int set_pct, input int tick_pct);
    int                roll;
    logic [CMD_W-1:0]  cmd;
    logic [DUR_W-1:0]  dur;
    roll = $urandom_range(0, 99);
    if (roll < set_pct) cmd = $urandom_range(0, 1) ? CMD_SET_PERIODIC : CMD_SET_ONCE;
    else if (roll < set_pct + tick_pct) cmd = CMD_TICK;
    else cmd = CMD_KILL;
    // Mostly short timers so that expiries come often; a few never expire in this run.
    roll = $urandom_range(0, 99);
    if (roll < 5) dur = '0;
    else if (roll < 15) dur = DUR_W'($urandom);
    else if (roll < 30) dur = DUR_W'($urandom_range(7, 60));
    else dur = DUR_W'($urandom_range(1, 6));
    issue(cmd, dur, EVT_W'($urandom), TASK_W'($urandom), $urandom, SLOT_W'($urandom));
  endtask

  task automatic random_phase(input int count, input int set_pct, input int tick_pct);
    for (int n = 0; n < count; n++) random_command(set_pct, tick_pct);
  endtask

  // Result side: alternating ready runs and stalls, plus one long hold-off.
  initial begin
    int  hold_left;
    int  run_left;
    logic ready_run;
    hold_left = 0;
    run_left = 0;
    ready_run = 1'b0;
    rsp_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        hold_left--;
        rsp_if.ready <= 1'b0;
      end else if (hold_req) begin
        hold_left = 600;
        rsp_if.ready <= 1'b0;
      end else begin
        if (run_left == 0) begin
          ready_run = !ready_run;
          if (ready_run) run_left = ($urandom_range(0, 7) == 0) ? 80 : $urandom_range(1, 25);
          else run_left = $urandom_range(1, 6);
        end
        run_left--;
        rsp_if.ready <= ready_run;
      end
    end
  end

  initial begin
    rst <= 1'b1;
    hold_req <= 1'b0;
    burst_left = 0;
    req_if.valid <= 1'b0;
    req_if.command <= CMD_TICK;
    req_if.duration <= '0;
    req_if.event_code <= '0;
    req_if.owner_task <= '0;
    req_if.payload_word <= '0;
    req_if.slot_index <= '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed part: rejections, field extremes, multiple expiries and kills.
    issue(CMD_TICK, '0, '0, '0, '0, '0);
    issue(CMD_SET_ONCE, '0, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 5'd31);
    issue(CMD_SET_PERIODIC, '0, '0, '0, '0, '0);
    issue(CMD_SET_ONCE, 31'd1, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 5'd31);
    issue(CMD_SET_PERIODIC, 31'd1, '0, '0, '0, '0);
    issue(CMD_SET_ONCE, 31'h7FFF_FFFF, 16'h5A5A, 16'hA5A5, 32'h1234_5678, '0);
    issue(CMD_SET_PERIODIC, 31'd2, 16'h0001, 16'h8000, 32'h8000_0001, '0);
    issue(CMD_TICK, '0, '0, '0, '0, '0);
    issue(CMD_TICK, '0, '0, '0, '0, '0);
    issue(CMD_KILL, '0, '0, '0, '0, 5'd0);
    issue(CMD_KILL, '0, '0, '0, '0, 5'd31);
    issue(CMD_KILL, '0, '0, '0, '0, 5'd1);
    issue(CMD_SET_ONCE, 31'd3, 16'h1111, 16'h2222, 32'h3333_3333, 5'd10);
    issue(CMD_SET_ONCE, 31'h4000_0000, 16'h7FFF, 16'hFFFE, 32'h7FFF_FFFE, 5'd21);
    issue(CMD_TICK, '0, '0, '0, '0, '0);
    issue(CMD_TICK, '0, '0, '0, '0, '0);
    issue(CMD_TICK, '0, '0, '0, '0, '0);
    issue(CMD_KILL, '0, '0, '0, '0, 5'd2);
    issue(CMD_KILL, '0, '0, '0, '0, 5'd3);
    issue(CMD_TICK, '0, '0, '0, '0, '0);

    // Random part: fill the table to rejection, then churn and drain it.
    random_phase(50, 85, 5);
    hold_req <= 1'b1;
    @(posedge clk);
    hold_req <= 1'b0;
    random_phase(60, 35, 45);
    random_phase(40, 5, 75);
    random_phase(50, 80, 10);
    random_phase(60, 40, 40);
    random_phase(50, 30, 30);
    random_phase(50, 10, 80);

    req_if.valid <= 1'b0;
    // The checker's count includes the last transaction only from the next edge on.
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (2 * NUM_TIMERS + 8) @(posedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/stt_pkg.sv
rtl/core/stt_if.sv
rtl/core/stt_ram.sv
rtl/core/software_timer_table.sv
bench/timer_table_checker.sv
bench/tb_software_timer_table.sv
